FILE: rtl/disk_contact_geometry_core_macros.svh
// Assertion macros used by the back end block of the contact geometry core.
// They expect a clock named clk and an active low reset named rst_n in scope.
`ifndef DISK_CONTACT_GEOMETRY_CORE_MACROS_SVH
`define DISK_CONTACT_GEOMETRY_CORE_MACROS_SVH

`define DCG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DCG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

FILE: rtl/dcg_pkg.sv
package dcg_pkg;

    localparam logic REQ_DISK = 1'b0;
    localparam logic REQ_SEG  = 1'b1;

    localparam int SQRT_STEPS  = 37;
    localparam int DIV_STEPS   = 15;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] own_pos_x;
        logic signed [31:0] own_pos_y;
        logic        [30:0] own_radius;
        logic signed [31:0] other_pos_x;
        logic signed [31:0] other_pos_y;
        logic        [30:0] other_size;
        logic signed [15:0] seg_dir_x;
        logic signed [15:0] seg_dir_y;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
    } in_t;

    typedef struct packed {
        logic               contacted;
        logic signed [31:0] overlap;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
        logic signed [31:0] arm_own_x;
        logic signed [31:0] arm_own_y;
        logic signed [31:0] arm_other_x;
        logic signed [31:0] arm_other_y;
    } out_t;

    typedef struct packed {
        logic               seg;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic        [30:0] r;
        logic        [30:0] h;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [34:0] ex;
        logic signed [34:0] ey;
    } work_t;

    typedef struct packed {
        logic               seg;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic        [30:0] r;
        logic        [30:0] h;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [34:0] rx;
        logic signed [34:0] ry;
        logic signed [36:0] bx;
        logic signed [36:0] by;
    } ctx_t;

    function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
        logic signed [63:0] b;
        b = v + 64'sd8192 - {63'd0, v[63]};
        return b >>> 14;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        else begin
            return v[31:0];
        end
    endfunction

    function automatic logic [36:0] mag37(input logic signed [36:0] v);
        logic signed [36:0] n;
        n = -v;
        return v[36] ? n : v;
    endfunction

endpackage

FILE: rtl/disk_contact_geometry_core.sv
// Contact geometry for one disk pair or disk and segment pair per transaction. The core takes
// a new pair every cycle while it does not raise pair_stall and returns one result per pair in
// order. The arithmetic pipeline holds the 37 stage square root that yields one distance bit
// per stage and the 15 stage divider that yields one bit of each normal component per stage;
// a four entry queue sits between the input register and the arithmetic pipeline, which
// advances as a whole while its result register is free.
module disk_contact_geometry_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pair_valid,
    output logic            pair_stall,
    input  dcg_pkg::in_t    pair,
    output logic            contact_valid,
    input  logic            contact_stall,
    output dcg_pkg::out_t   contact
);

    logic            push;
    logic            full;
    dcg_pkg::work_t  push_work;
    logic            pop;
    logic            avail;
    dcg_pkg::work_t  pop_work;

    dcg_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (pair_valid),
        .stall (pair_stall),
        .data  (pair),
        .push  (push),
        .full  (full),
        .work  (push_work)
    );

    dcg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .push_work (push_work),
        .pop       (pop),
        .avail     (avail),
        .pop_work  (pop_work)
    );

    dcg_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .avail (avail),
        .work  (pop_work),
        .pop   (pop),
        .valid (contact_valid),
        .stall (contact_stall),
        .data  (contact)
    );

endmodule

FILE: rtl/dcg_front.sv
module dcg_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            stall,
    input  dcg_pkg::in_t    data,
    output logic            push,
    input  logic            full,
    output dcg_pkg::work_t  work
);

    logic            f_valid_reg;
    logic            f_valid_next;
    dcg_pkg::work_t  f_work_reg;
    dcg_pkg::work_t  f_work_next;
    logic signed [34:0] px;
    logic signed [34:0] py;
    logic signed [34:0] ox;
    logic signed [34:0] oy;
    logic signed [34:0] sx;
    logic signed [34:0] sy;
    logic            accept;

    assign stall  = f_valid_reg && full;
    assign accept = valid && !stall;
    assign push   = f_valid_reg;
    assign work   = f_work_reg;

    always_comb
    begin
        px = data.own_pos_x;
        py = data.own_pos_y;
        ox = data.other_pos_x;
        oy = data.other_pos_y;
        sx = data.shift_x;
        sy = data.shift_y;
        f_work_next.seg = data.req_type;
        f_work_next.px  = data.own_pos_x;
        f_work_next.py  = data.own_pos_y;
        f_work_next.r   = data.own_radius;
        f_work_next.h   = data.other_size;
        f_work_next.ox  = data.other_pos_x;
        f_work_next.oy  = data.other_pos_y;
        f_work_next.dx  = data.seg_dir_x;
        f_work_next.dy  = data.seg_dir_y;
        f_work_next.sx  = data.shift_x;
        f_work_next.sy  = data.shift_y;
        unique case (data.req_type)
            dcg_pkg::REQ_SEG:
            begin
                f_work_next.ex = px + sx - ox;
                f_work_next.ey = py + sy - oy;
            end
            dcg_pkg::REQ_DISK:
            begin
                f_work_next.ex = ox + sx - px;
                f_work_next.ey = oy + sy - py;
            end
        endcase
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end
        else if (f_valid_reg && !full) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            f_valid_reg <= 1'b0;
        end
        else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            f_work_reg <= f_work_next;
        end
    end

endmodule

FILE: rtl/dcg_queue.sv
module dcg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  dcg_pkg::work_t  push_work,
    input  logic            pop,
    output logic            avail,
    output dcg_pkg::work_t  pop_work
);

    dcg_pkg::work_t                  entry_reg [0:dcg_pkg::QUEUE_DEPTH-1];
    logic [dcg_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [dcg_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [dcg_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [dcg_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [dcg_pkg::QCNT_W-1:0]      count_reg;
    logic [dcg_pkg::QCNT_W-1:0]      count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full     = count_reg == dcg_pkg::QCNT_W'(dcg_pkg::QUEUE_DEPTH);
    assign avail    = count_reg != '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && avail;
    assign pop_work = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? dcg_pkg::QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? dcg_pkg::QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_work;
        end
    end

endmodule

FILE: rtl/dcg_back.sv
`include "disk_contact_geometry_core_macros.svh"

module dcg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,
    input  dcg_pkg::work_t  work,
    output logic            pop,
    output logic            valid,
    input  logic            stall,
    output dcg_pkg::out_t   data
);

    localparam int SQ_N = dcg_pkg::SQRT_STEPS;
    localparam int DV_N = dcg_pkg::DIV_STEPS;

    logic en;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    dcg_pkg::work_t     w1_reg, w2_reg, w3_reg;
    logic signed [50:0] mx1_next, my1_next, mx1_reg, my1_reg;
    logic signed [31:0] t2_next, t2_reg;
    logic signed [47:0] ux3_next, uy3_next, ux3_reg, uy3_reg;
    dcg_pkg::ctx_t      c4_next, c4_reg, c5_reg;
    logic [36:0]        magx5, magy5;
    logic [63:0]        llx5_reg, lly5_reg;
    logic [36:0]        hlx5_reg, hly5_reg;
    logic [9:0]         hhx5_reg, hhy5_reg;

    logic signed [51:0] s2_sum;
    logic signed [63:0] t2_rnd, h64, nh64;
    logic signed [63:0] s4_ox, s4_oy, s4_sx, s4_sy, s4_px, s4_py, s4_rx, s4_ry, s4_bx, s4_by;

    logic               sq_v_reg    [0:SQ_N];
    dcg_pkg::ctx_t      sq_c_reg    [0:SQ_N];
    logic [73:0]        sq_n_reg    [0:SQ_N];
    logic [39:0]        sq_rem_reg  [0:SQ_N];
    logic [36:0]        sq_root_reg [0:SQ_N];
    logic [73:0]        n6_next;

    logic               dv_v_reg  [0:DV_N];
    dcg_pkg::ctx_t      dv_c_reg  [0:DV_N];
    logic [36:0]        dv_d_reg  [0:DV_N];
    logic signed [39:0] dv_ov_reg [0:DV_N];
    logic [51:0]        dv_nx_reg [0:DV_N];
    logic [51:0]        dv_ny_reg [0:DV_N];
    logic [36:0]        dv_rx_reg [0:DV_N];
    logic [36:0]        dv_ry_reg [0:DV_N];
    logic [14:0]        dv_qx_reg [0:DV_N];
    logic [14:0]        dv_qy_reg [0:DV_N];
    logic [39:0]        ov0_sum;
    logic [51:0]        nx0, ny0;

    logic               vm_reg;
    dcg_pkg::ctx_t      cm_reg;
    logic signed [39:0] ovm_reg;
    logic signed [15:0] nxm_next, nym_next, nxm_reg, nym_reg;
    logic signed [47:0] prx_reg, phx_reg, pry_reg, phy_reg;

    logic               vs_reg;
    dcg_pkg::ctx_t      cs_reg;
    logic signed [39:0] ovs_reg;
    logic signed [15:0] nxs_reg, nys_reg;
    logic signed [39:0] cx_next, cy_next, cx_reg, cy_reg;
    logic signed [63:0] sx_acc, sy_acc;

    logic               vo_reg;
    dcg_pkg::out_t      o_next, o_reg;
    logic signed [63:0] cx64, cy64;

    assign en    = !vo_reg || !stall;
    assign pop   = en && avail;
    assign valid = vo_reg;
    assign data  = o_reg;

    always_comb
    begin
        mx1_next = work.ex * work.dx;
        my1_next = work.ey * work.dy;
        s2_sum   = 52'(mx1_reg) + 52'(my1_reg);
        t2_rnd   = dcg_pkg::rnd14(s2_sum);
        h64      = {33'd0, w1_reg.h};
        nh64     = -h64;
        if (t2_rnd > h64) begin
            t2_next = h64[31:0];
        end
        else if (t2_rnd < nh64) begin
            t2_next = nh64[31:0];
        end
        else begin
            t2_next = t2_rnd[31:0];
        end
        ux3_next = w2_reg.dx * t2_reg;
        uy3_next = w2_reg.dy * t2_reg;
    end

    always_comb
    begin
        s4_ox = w3_reg.ox;
        s4_oy = w3_reg.oy;
        s4_sx = w3_reg.sx;
        s4_sy = w3_reg.sy;
        s4_px = w3_reg.px;
        s4_py = w3_reg.py;
        if (w3_reg.seg) begin
            s4_rx = s4_ox + dcg_pkg::rnd14(ux3_reg);
            s4_ry = s4_oy + dcg_pkg::rnd14(uy3_reg);
            s4_bx = s4_rx + s4_sx - s4_px;
            s4_by = s4_ry + s4_sy - s4_py;
        end
        else begin
            s4_rx = s4_ox + s4_sx;
            s4_ry = s4_oy + s4_sy;
            s4_bx = s4_rx - s4_px;
            s4_by = s4_ry - s4_py;
        end
        c4_next.seg = w3_reg.seg;
        c4_next.px  = w3_reg.px;
        c4_next.py  = w3_reg.py;
        c4_next.r   = w3_reg.r;
        c4_next.h   = w3_reg.h;
        c4_next.sx  = w3_reg.sx;
        c4_next.sy  = w3_reg.sy;
        c4_next.rx  = s4_rx[34:0];
        c4_next.ry  = s4_ry[34:0];
        c4_next.bx  = s4_bx[36:0];
        c4_next.by  = s4_by[36:0];
    end

    assign magx5 = dcg_pkg::mag37(c4_reg.bx);
    assign magy5 = dcg_pkg::mag37(c4_reg.by);

    always_comb
    begin
        n6_next = (74'(hhx5_reg) << 64) + (74'(hlx5_reg) << 33) + 74'(llx5_reg)
                + (74'(hhy5_reg) << 64) + (74'(hly5_reg) << 33) + 74'(lly5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (en) begin
            v1_reg      <= avail;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            sq_v_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            w1_reg         <= work;
            mx1_reg        <= mx1_next;
            my1_reg        <= my1_next;
            w2_reg         <= w1_reg;
            t2_reg         <= t2_next;
            w3_reg         <= w2_reg;
            ux3_reg        <= ux3_next;
            uy3_reg        <= uy3_next;
            c4_reg         <= c4_next;
            c5_reg         <= c4_reg;
            llx5_reg       <= magx5[31:0] * magx5[31:0];
            lly5_reg       <= magy5[31:0] * magy5[31:0];
            hlx5_reg       <= magx5[36:32] * magx5[31:0];
            hly5_reg       <= magy5[36:32] * magy5[31:0];
            hhx5_reg       <= magx5[36:32] * magx5[36:32];
            hhy5_reg       <= magy5[36:32] * magy5[36:32];
            sq_c_reg[0]    <= c5_reg;
            sq_n_reg[0]    <= n6_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // Each square root stage settles one root bit from one pair of radicand bits.
    for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
        localparam int K = SQ_N - 1 - i;
        logic [39:0] r2;
        logic [39:0] trial;
        logic [39:0] rem_next;
        logic [36:0] root_next;

        always_comb
        begin
            r2    = {sq_rem_reg[i][37:0], sq_n_reg[i][2*K+1 -: 2]};
            trial = {1'b0, sq_root_reg[i], 2'b01};
            if (r2 >= trial) begin
                rem_next  = r2 - trial;
                root_next = {sq_root_reg[i][35:0], 1'b1};
            end
            else begin
                rem_next  = r2;
                root_next = {sq_root_reg[i][35:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                sq_v_reg[i+1] <= 1'b0;
            end
            else if (en) begin
                sq_v_reg[i+1] <= sq_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                sq_c_reg[i+1]    <= sq_c_reg[i];
                sq_n_reg[i+1]    <= sq_n_reg[i];
                sq_rem_reg[i+1]  <= rem_next;
                sq_root_reg[i+1] <= root_next;
            end
        end
    end

    always_comb
    begin
        ov0_sum = sq_c_reg[SQ_N].seg ? 40'(sq_c_reg[SQ_N].r)
                                     : 40'(sq_c_reg[SQ_N].r) + 40'(sq_c_reg[SQ_N].h);
        nx0 = {1'b0, dcg_pkg::mag37(sq_c_reg[SQ_N].bx), 14'd0}
            + 52'(sq_root_reg[SQ_N] >> 1);
        ny0 = {1'b0, dcg_pkg::mag37(sq_c_reg[SQ_N].by), 14'd0}
            + 52'(sq_root_reg[SQ_N] >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en) begin
            dv_v_reg[0] <= sq_v_reg[SQ_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            dv_c_reg[0]  <= sq_c_reg[SQ_N];
            dv_d_reg[0]  <= sq_root_reg[SQ_N];
            dv_ov_reg[0] <= ov0_sum - 40'(sq_root_reg[SQ_N]);
            dv_nx_reg[0] <= nx0;
            dv_ny_reg[0] <= ny0;
            dv_rx_reg[0] <= nx0[51:15];
            dv_ry_reg[0] <= ny0[51:15];
            dv_qx_reg[0] <= '0;
            dv_qy_reg[0] <= '0;
        end
    end

    // Each divider stage produces one quotient bit of both normal components.
    for (genvar i = 0; i < DV_N; i++) begin : g_div
        localparam int K = DV_N - 1 - i;
        logic [37:0] rx2, ry2, dd;
        logic [36:0] rx_next, ry_next;
        logic        bx_bit, by_bit;

        always_comb
        begin
            dd     = {1'b0, dv_d_reg[i]};
            rx2    = {dv_rx_reg[i], dv_nx_reg[i][K]};
            ry2    = {dv_ry_reg[i], dv_ny_reg[i][K]};
            bx_bit = rx2 >= dd;
            by_bit = ry2 >= dd;
            rx_next = bx_bit ? 37'(rx2 - dd) : rx2[36:0];
            ry_next = by_bit ? 37'(ry2 - dd) : ry2[36:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                dv_v_reg[i+1] <= 1'b0;
            end
            else if (en) begin
                dv_v_reg[i+1] <= dv_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                dv_c_reg[i+1]  <= dv_c_reg[i];
                dv_d_reg[i+1]  <= dv_d_reg[i];
                dv_ov_reg[i+1] <= dv_ov_reg[i];
                dv_nx_reg[i+1] <= dv_nx_reg[i];
                dv_ny_reg[i+1] <= dv_ny_reg[i];
                dv_rx_reg[i+1] <= rx_next;
                dv_ry_reg[i+1] <= ry_next;
                dv_qx_reg[i+1] <= {dv_qx_reg[i][13:0], bx_bit};
                dv_qy_reg[i+1] <= {dv_qy_reg[i][13:0], by_bit};
            end
        end
    end

    always_comb
    begin
        if (dv_d_reg[DV_N] == '0) begin
            nxm_next = '0;
            nym_next = '0;
        end
        else begin
            nxm_next = dv_c_reg[DV_N].bx[36] ? -$signed({1'b0, dv_qx_reg[DV_N]})
                                             : $signed({1'b0, dv_qx_reg[DV_N]});
            nym_next = dv_c_reg[DV_N].by[36] ? -$signed({1'b0, dv_qy_reg[DV_N]})
                                             : $signed({1'b0, dv_qy_reg[DV_N]});
        end
    end

    always_comb
    begin
        sx_acc = 64'(cm_reg.px) + dcg_pkg::rnd14(prx_reg) + 64'(cm_reg.rx)
               - dcg_pkg::rnd14(phx_reg);
        sy_acc = 64'(cm_reg.py) + dcg_pkg::rnd14(pry_reg) + 64'(cm_reg.ry)
               - dcg_pkg::rnd14(phy_reg);
        if (cm_reg.seg) begin
            cx_next = 40'(cm_reg.rx);
            cy_next = 40'(cm_reg.ry);
        end
        else begin
            cx_next = sx_acc[40:1];
            cy_next = sy_acc[40:1];
        end
    end

    always_comb
    begin
        cx64 = cx_reg;
        cy64 = cy_reg;
        o_next             = '0;
        o_next.contacted   = !ovs_reg[39];
        o_next.overlap     = dcg_pkg::sat32(ovs_reg);
        if (!ovs_reg[39]) begin
            o_next.normal_x  = nxs_reg;
            o_next.normal_y  = nys_reg;
            o_next.contact_x = dcg_pkg::sat32(cx64);
            o_next.contact_y = dcg_pkg::sat32(cy64);
            o_next.arm_own_x = dcg_pkg::sat32(cx64 - 64'(cs_reg.px));
            o_next.arm_own_y = dcg_pkg::sat32(cy64 - 64'(cs_reg.py));
            if (cs_reg.seg) begin
                o_next.arm_other_x = dcg_pkg::sat32(-64'(cs_reg.sx));
                o_next.arm_other_y = dcg_pkg::sat32(-64'(cs_reg.sy));
            end
            else begin
                o_next.arm_other_x = dcg_pkg::sat32(cx64 - 64'(cs_reg.rx));
                o_next.arm_other_y = dcg_pkg::sat32(cy64 - 64'(cs_reg.ry));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vm_reg <= 1'b0;
            vs_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en) begin
            vm_reg <= dv_v_reg[DV_N];
            vs_reg <= vm_reg;
            vo_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            cm_reg  <= dv_c_reg[DV_N];
            ovm_reg <= dv_ov_reg[DV_N];
            nxm_reg <= nxm_next;
            nym_reg <= nym_next;
            prx_reg <= nxm_next * $signed({1'b0, dv_c_reg[DV_N].r});
            phx_reg <= nxm_next * $signed({1'b0, dv_c_reg[DV_N].h});
            pry_reg <= nym_next * $signed({1'b0, dv_c_reg[DV_N].r});
            phy_reg <= nym_next * $signed({1'b0, dv_c_reg[DV_N].h});
            cs_reg  <= cm_reg;
            ovs_reg <= ovm_reg;
            nxs_reg <= nxm_reg;
            nys_reg <= nym_reg;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            o_reg   <= o_next;
        end
    end

    `DCG_ASSERT_IMPL(a_sqrt_rem, sq_v_reg[SQ_N], (sq_rem_reg[SQ_N] <= {3'b0, sq_root_reg[SQ_N], 1'b0}), "Square root remainder exceeds twice the root.")
    `DCG_ASSERT_IMPL(a_div_start, (dv_v_reg[0] && dv_d_reg[0] != '0), (dv_rx_reg[0] < dv_d_reg[0]), "Normal quotient would overflow its width.")
    `DCG_ASSERT_IMPL(a_hit_sign, (valid && data.contacted), (!data.overlap[31]), "Contact flagged with a negative overlap.")
    `DCG_ASSERT_IMPL(a_miss_zero, (valid && !data.contacted), (data.normal_x == '0 && data.normal_y == '0 && data.contact_x == '0 && data.arm_other_y == '0), "A transaction without contact carries geometry.")
    `DCG_ASSERT_ALWAYS(a_norm_range, (!valid || (data.normal_x <= 16'sd16384 && data.normal_x >= -16'sd16384)), "Normal component out of range.")

endmodule

FILE: bench/disk_contact_geometry_core_test.sv
`timescale 1ns / 1ps

module disk_contact_geometry_core_test;

    import dcg_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic  clk;
    logic  rst_n;
    logic  pair_valid;
    logic  pair_stall;
    in_t   pair;
    logic  contact_valid;
    logic  contact_stall;
    out_t  contact;

    out_t  expected_contacts[$];
    int    error_count;
    int    pairs_sent;
    int    contacts_checked;
    int    contacts_hit;
    int    segment_pairs;
    int    idle_cycles;
    int    burst_left;

    disk_contact_geometry_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair_valid    (pair_valid),
        .pair_stall    (pair_stall),
        .pair          (pair),
        .contact_valid (contact_valid),
        .contact_stall (contact_stall),
        .contact       (contact)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint round_q14(longint v);
        longint m;
        m = ((v < 0) ? -v : v) + 64'sd8192;
        m = m >>> 14;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint branch_length(longint bx, longint by);
        logic [127:0] ax;
        logic [127:0] ay;
        logic [127:0] sum_sq;
        logic [127:0] trial;
        logic [127:0] root;
        ax = (bx < 0) ? -bx : bx;
        ay = (by < 0) ? -by : by;
        sum_sq = ax * ax + ay * ay;
        root = '0;
        for (int b = 36; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= sum_sq)
            begin
                root = trial;
            end
        end
        return longint'(root[63:0]);
    endfunction

    function automatic longint unit_component(longint b, longint d);
        longint q;
        if (d == 0)
        begin
            return 0;
        end
        q = (((b < 0) ? -b : b) * 16384 + d / 2) / d;
        return (b < 0) ? -q : q;
    endfunction

    function automatic out_t contact_of(in_t p);
        out_t   res;
        longint px;
        longint py;
        longint r;
        longint ox;
        longint oy;
        longint h;
        longint dx;
        longint dy;
        longint sx;
        longint sy;
        longint t;
        longint rx;
        longint ry;
        longint bx;
        longint by;
        longint d;
        longint ov;
        longint nx;
        longint ny;
        longint cx;
        longint cy;
        longint atx;
        longint aty;
        px = p.own_pos_x;
        py = p.own_pos_y;
        r  = longint'(p.own_radius);
        ox = p.other_pos_x;
        oy = p.other_pos_y;
        h  = longint'(p.other_size);
        dx = p.seg_dir_x;
        dy = p.seg_dir_y;
        sx = p.shift_x;
        sy = p.shift_y;
        if (p.req_type == REQ_SEG)
        begin
            t = round_q14((px + sx - ox) * dx + (py + sy - oy) * dy);
            if (t > h)
            begin
                t = h;
            end
            if (t < -h)
            begin
                t = -h;
            end
            rx = ox + round_q14(dx * t);
            ry = oy + round_q14(dy * t);
            bx = rx + sx - px;
            by = ry + sy - py;
            d  = branch_length(bx, by);
            ov = r - d;
        end
        else
        begin
            rx = ox + sx;
            ry = oy + sy;
            bx = rx - px;
            by = ry - py;
            d  = branch_length(bx, by);
            ov = r + h - d;
        end
        res = '0;
        res.overlap = 32'(clip32(ov));
        if (ov >= 0)
        begin
            nx = unit_component(bx, d);
            ny = unit_component(by, d);
            if (p.req_type == REQ_SEG)
            begin
                cx  = rx;
                cy  = ry;
                atx = -sx;
                aty = -sy;
            end
            else
            begin
                cx  = (px + round_q14(nx * r) + rx - round_q14(nx * h)) >>> 1;
                cy  = (py + round_q14(ny * r) + ry - round_q14(ny * h)) >>> 1;
                atx = cx - rx;
                aty = cy - ry;
            end
            res.contacted   = 1'b1;
            res.normal_x    = 16'(nx);
            res.normal_y    = 16'(ny);
            res.contact_x   = 32'(clip32(cx));
            res.contact_y   = 32'(clip32(cy));
            res.arm_own_x   = 32'(clip32(cx - px));
            res.arm_own_y   = 32'(clip32(cy - py));
            res.arm_other_x = 32'(clip32(atx));
            res.arm_other_y = 32'(clip32(aty));
        end
        return res;
    endfunction

    // Sends one pair; the sender runs in bursts separated by random gaps.
    task automatic send_pair(in_t p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                pair_valid <= 1'b0;
                pair       <= in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom});
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        pair_valid <= 1'b1;
        pair       <= p;
        forever
        begin
            @(posedge clk);
            if (!pair_stall)
            begin
                break;
            end
        end
        expected_contacts.push_back(contact_of(p));
        pairs_sent++;
        if (p.req_type == REQ_SEG)
        begin
            segment_pairs++;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        pair_valid <= 1'b0;
        burst_left = 0;
        while (expected_contacts.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: mismatch in %s: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_t exp_c;
        if (rst_n && contact_valid && !contact_stall)
        begin
            if (expected_contacts.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %p", $time, contact);
                error_count++;
            end
            else
            begin
                exp_c = expected_contacts.pop_front();
                check_field("contacted", exp_c.contacted, contact.contacted);
                check_field("overlap", exp_c.overlap, contact.overlap);
                check_field("normal_x", exp_c.normal_x, contact.normal_x);
                check_field("normal_y", exp_c.normal_y, contact.normal_y);
                check_field("contact_x", exp_c.contact_x, contact.contact_x);
                check_field("contact_y", exp_c.contact_y, contact.contact_y);
                check_field("arm_own_x", exp_c.arm_own_x, contact.arm_own_x);
                check_field("arm_own_y", exp_c.arm_own_y, contact.arm_own_y);
                check_field("arm_other_x", exp_c.arm_other_x, contact.arm_other_x);
                check_field("arm_other_y", exp_c.arm_other_y, contact.arm_other_y);
                contacts_checked++;
                if (exp_c.contacted)
                begin
                    contacts_hit++;
                end
            end
        end
    end

    // The result side stalls in stretches: never, at random, or mostly.
    initial
    begin
        int mode;
        int stretch;
        contact_stall = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(10, 200);
            repeat (stretch)
            begin
                @(negedge clk);
                case (mode)
                    0: contact_stall <= 1'b0;
                    1: contact_stall <= $urandom_range(0, 1);
                    default: contact_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pair_valid && !pair_stall) || (contact_valid && !contact_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic in_t noise_pair();
        return in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic logic signed [15:0] unit_dir(bit want_y);
        logic signed [15:0] c;
        logic signed [15:0] s;
        case ($urandom_range(0, 5))
            0: begin c = 16384;  s = 0;      end
            1: begin c = 0;      s = 16384;  end
            2: begin c = 11585;  s = 11585;  end
            3: begin c = -11585; s = 11585;  end
            4: begin c = 13107;  s = -9830;  end
            default: begin c = $urandom_range(0, 32767) - 16384; s = $urandom_range(0, 16384); end
        endcase
        return want_y ? s : c;
    endfunction

    // Builds a pair whose bodies lie close to each other so that contact is frequent.
    function automatic in_t near_pair(logic kind);
        in_t p;
        int  k;
        int  off_x;
        int  off_y;
        k = $urandom_range(2, 30);
        off_x = $signed($urandom) >>> k;
        off_y = $signed($urandom) >>> k;
        p = noise_pair();
        p.req_type = kind;
        if ($urandom_range(0, 2) == 0)
        begin
            p.shift_x = 0;
            p.shift_y = 0;
        end
        else
        begin
            p.shift_x = $signed($urandom) >>> $urandom_range(1, 31);
            p.shift_y = $signed($urandom) >>> $urandom_range(1, 31);
        end
        p.own_radius = 31'($urandom >> (k - 1));
        p.other_size = 31'($urandom >> (k - 1));
        if (kind == REQ_SEG)
        begin
            p.seg_dir_x   = unit_dir(1'b0);
            p.seg_dir_y   = unit_dir(1'b1);
            p.other_pos_x = p.own_pos_x + p.shift_x + off_x;
            p.other_pos_y = p.own_pos_y + p.shift_y + off_y;
        end
        else
        begin
            p.other_pos_x = p.own_pos_x - p.shift_x + off_x;
            p.other_pos_y = p.own_pos_y - p.shift_y + off_y;
        end
        return p;
    endfunction

    function automatic in_t make_pair(logic kind, int px, int py, int r, int ox, int oy,
                                      int h, int dx, int dy, int sx, int sy);
        in_t p;
        p.req_type    = kind;
        p.own_pos_x   = px;
        p.own_pos_y   = py;
        p.own_radius  = 31'(r);
        p.other_pos_x = ox;
        p.other_pos_y = oy;
        p.other_size  = 31'(h);
        p.seg_dir_x   = 16'(dx);
        p.seg_dir_y   = 16'(dy);
        p.shift_x     = sx;
        p.shift_y     = sy;
        return p;
    endfunction

    task automatic test_disk_cases();
        send_pair(make_pair(REQ_DISK, 0, 0, 65536, 98304, 0, 65536, 0, 0, 0, 0));
        send_pair(make_pair(REQ_DISK, 0, 0, 65536, 200000, 0, 65536, 0, 0, 0, 0));
        send_pair(make_pair(REQ_DISK, 0, 0, 65536, 131072, 0, 65536, 0, 0, 0, 0));
        send_pair(make_pair(REQ_DISK, 1000, -1000, 5000, 1000, -1000, 0, 0, 0, 0, 0));
        send_pair(make_pair(REQ_DISK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(REQ_DISK, 10, 20, 100, 0, 0, 100, 0, 0, 15, 25));
        send_pair(make_pair(REQ_DISK, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0, 0,
                            32'h80000000, 32'h80000000));
        send_pair(make_pair(REQ_DISK, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0,
                            32'h7FFFFFFF, 32'h7FFFFFFF));
        send_pair(make_pair(REQ_DISK, 32'h80000000, 32'h80000000, 0, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 0, 16'hFFFF, 16'h8000, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_pair(make_pair(REQ_DISK, -300, 400, 600, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_segment_cases();
        send_pair(make_pair(REQ_SEG, 0, 65536, 98304, 0, 0, 327680, 16384, 0, 0, 0));
        send_pair(make_pair(REQ_SEG, 1000000, 30000, 65536, 0, 0, 327680, 16384, 0, 0, 0));
        send_pair(make_pair(REQ_SEG, -1000000, -30000, 65536, 0, 0, 327680, 16384, 0, 0, 0));
        send_pair(make_pair(REQ_SEG, 0, 0, 4096, 0, 0, 65536, 0, 16384, 0, 0));
        send_pair(make_pair(REQ_SEG, 0, 0, 65536, 300000, 300000, 65536, 11585, 11585,
                            300000, 310000));
        send_pair(make_pair(REQ_SEG, 50000, 70000, 90000, 0, 0, 200000, 20000, 5000, 0, 0));
        send_pair(make_pair(REQ_SEG, 0, 500000, 65536, 0, 0, 65536, 16384, 0, 0, 0));
        send_pair(make_pair(REQ_SEG, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                            32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h8000,
                            32'h7FFFFFFF, 32'h80000000));
        send_pair(make_pair(REQ_SEG, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h8000, 16'h7FFF,
                            32'h80000000, 32'h7FFFFFFF));
        send_pair(make_pair(REQ_SEG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(REQ_SEG, 5, 5, 1000, 0, 0, 100, -16384, -16384, 0, 0));
    endtask

    task automatic test_random_pairs(int count);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1: send_pair(noise_pair());
                2, 3, 4, 5: send_pair(near_pair(REQ_DISK));
                default: send_pair(near_pair(REQ_SEG));
            endcase
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        pair_valid  = 1'b0;
        pair        = '0;
        error_count = 0;
        pairs_sent  = 0;
        contacts_checked = 0;
        contacts_hit = 0;
        segment_pairs = 0;
        idle_cycles = 0;
        burst_left  = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_disk_cases();
        test_segment_cases();
        wait_drained();
        test_random_pairs(500);
        wait_drained();
        test_random_pairs(525);
        wait_drained();
        repeat (100) @(negedge clk);

        $display("Checked %0d of %0d pairs (%0d segment pairs, %0d in contact).",
                 contacts_checked, pairs_sent, segment_pairs, contacts_hit);
        if (error_count == 0 && expected_contacts.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", error_count,
                     expected_contacts.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
